/* rtl/seven_zip_header_validator_core_macros.svh */
// Assertion macros shared by the checker of the 7z start-header validator.
// Each macro expands to one labelled concurrent assertion on a clock and an active-low reset.
`ifndef SEVEN_ZIP_HEADER_VALIDATOR_CORE_MACROS_SVH
`define SEVEN_ZIP_HEADER_VALIDATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVZH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svzh: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SVZH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svzh: next-cycle check failed");

`endif

/* rtl/svzh_pkg.sv */
// Types, constants and helper functions of the 7z start-header validator.
// No dependencies; imported by every module of the block.
`default_nettype none

package svzh_pkg;

    localparam int IDX_W       = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [IDX_W-1:0] IDX_SIG_END   = 5'd5;
    localparam logic [IDX_W-1:0] IDX_MAJOR     = 5'd6;
    localparam logic [IDX_W-1:0] IDX_MINOR     = 5'd7;
    localparam logic [IDX_W-1:0] IDX_CRC_FIRST = 5'd12;
    localparam logic [IDX_W-1:0] IDX_OFF_FIRST = 5'd12;
    localparam logic [IDX_W-1:0] IDX_SIZE_FIRST = 5'd20;
    localparam logic [IDX_W-1:0] IDX_TOTAL     = 5'd28;
    localparam logic [IDX_W-1:0] IDX_LAST      = 5'd31;

    localparam logic [35:0] HEADER_LEN   = 36'd32;
    localparam logic [7:0]  MAX_MINOR    = 8'd5;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        K_SHORT = 2'd0,
        K_START = 2'd1,
        K_BODY  = 2'd2,
        K_LAST  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_NO_MATCH  = 2'd0,
        ST_NEED_MORE = 2'd1,
        ST_PARTIAL   = 2'd2,
        ST_MATCHED   = 2'd3
    } t_status;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data_byte;
        logic [39:0]      bytes_available;
        logic             final_chunk;
    } t_item;

    typedef struct packed {
        t_status      status;
        logic [35:0]  match_length;
        logic         crc_ok;
        logic [7:0]   version_major;
        logic [7:0]   version_minor;
        logic [63:0]  hdr_offset;
        logic [63:0]  hdr_size;
    } t_result;

    function automatic logic [7:0] sig_byte(input logic [2:0] pos);
        logic [7:0] v;
        case (pos)
            3'd0:    v = 8'h37;
            3'd1:    v = 8'h7A;
            3'd2:    v = 8'hBC;
            3'd3:    v = 8'hAF;
            3'd4:    v = 8'h27;
            3'd5:    v = 8'h1C;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Reflected CRC-32, one byte per call.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // True when a header field is at most 2^34.
    function automatic logic field_in_range(input logic [63:0] f);
        return (f[63:35] == 29'd0) && (!f[34] || (f[33:0] == 34'd0));
    endfunction

endpackage

`default_nettype wire

/* rtl/seven_zip_header_validator_core.sv */
// Checks candidate 7z start headers fed one byte per item and reports one status per candidate.
// Takes one byte every cycle while the queue has room: the front end tags each byte, a four-entry
// queue decouples it from the back end, and the back end updates the CRC-32 one byte per cycle
// unless a result waits on the output. A result is registered when the byte that causes it (the
// start byte of a candidate with fewer than 32 bytes available, or byte 31 of a full one) leaves
// the queue; the queue absorbs output stalls, and input is held off only when it fills. Bytes
// outside a candidate give no result. Depends on svzh_pkg, svzh_front, svzh_queue and svzh_back.
`default_nettype none

module seven_zip_header_validator_core
    import svzh_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,   // data_byte[7:0], bytes_available[47:8]
    input  wire logic         s_axis_tuser,   // start_req
    input  wire logic         s_axis_tlast,   // final_chunk
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output      logic [183:0] m_axis_tdata,   // match_length[35:0], crc_ok[36],
                                              // version_major[44:37], version_minor[52:45],
                                              // header_offset[116:53],
                                              // header_size[180:117], zero pad[183:181]
    output      logic [1:0]   m_axis_tuser    // status
);

    logic    accept;
    logic    push;
    t_item   push_item;
    logic    q_full;
    logic    q_valid;
    t_item   q_head;
    logic    pop;
    t_result result;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    svzh_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_data_byte       (s_axis_tdata[7:0]),
        .i_start_req       (s_axis_tuser),
        .i_bytes_available (s_axis_tdata[47:8]),
        .i_final_chunk     (s_axis_tlast),
        .o_push            (push),
        .o_item            (push_item)
    );

    svzh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (pop)
    );

    svzh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result)
    );

    assign m_axis_tuser = result.status;
    assign m_axis_tdata = {3'd0,
                           result.hdr_size,
                           result.hdr_offset,
                           result.version_minor,
                           result.version_major,
                           result.crc_ok,
                           result.match_length};

endmodule

`default_nettype wire

/* rtl/svzh_front.sv */
// Front end of the validator: takes input bytes and tags each with its role in a candidate.
// Depends on svzh_pkg; feeds svzh_queue.
`default_nettype none

module svzh_front
    import svzh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_start_req,
    input  wire logic [39:0] i_bytes_available,
    input  wire logic        i_final_chunk,
    output      logic        o_push,
    output      t_item       o_item
);

    logic             r_active;
    logic [IDX_W-1:0] r_idx;
    logic             n_active;
    logic [IDX_W-1:0] n_idx;
    logic             short_cand;

    assign short_cand = (i_bytes_available[39:5] == 35'd0);

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        o_push   = 1'b0;
        o_item.kind            = K_BODY;
        o_item.idx             = r_idx;
        o_item.data_byte       = i_data_byte;
        o_item.bytes_available = i_bytes_available;
        o_item.final_chunk     = i_final_chunk;
        if (i_accept) begin
            if (i_start_req) begin
                o_push     = 1'b1;
                o_item.idx = '0;
                if (short_cand) begin
                    o_item.kind = K_SHORT;
                    n_active    = 1'b0;
                end else begin
                    o_item.kind = K_START;
                    n_active    = 1'b1;
                    n_idx       = IDX_W'(1);
                end
            end else if (r_active) begin
                // Bytes outside a candidate are dropped here and never reach the queue.
                o_push = 1'b1;
                if (r_idx == IDX_LAST) begin
                    o_item.kind = K_LAST;
                    n_active    = 1'b0;
                end
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
        end
    end

endmodule

`default_nettype wire

/* rtl/svzh_queue.sv */
// Short first-in first-out queue of tagged bytes between front and back ends.
// Depends on svzh_pkg for the entry type and depth.
`default_nettype none

module svzh_queue
    import svzh_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output      logic  o_full,
    output      logic  o_valid,
    output      t_item o_head,
    input  wire logic  i_pop
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/svzh_back.sv */
// Back end of the validator: collects header fields, runs the CRC and forms the status result.
// Depends on svzh_pkg; drains svzh_queue and holds the output register.
`default_nettype none

module svzh_back
    import svzh_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_head_valid,
    input  wire t_item   i_head,
    output      logic    o_pop,
    output      logic    o_valid,
    input  wire logic    i_ready,
    output      t_result o_result
);

    logic        r_sig_good;
    logic [31:0] r_crc;
    logic [31:0] r_stored_crc;
    logic [63:0] r_offset;
    logic [63:0] r_size;
    logic [7:0]  r_major;
    logic [7:0]  r_minor;
    logic [39:0] r_avail;
    logic        r_final;
    logic [35:0] r_total;
    logic        r_fields_ok;
    logic        r_out_valid;
    t_result     r_out;

    logic        n_sig_good;
    logic [31:0] n_crc;
    t_result     n_result;
    logic        produces;
    logic        out_free;
    logic        is_start;
    logic [31:0] crc_base;
    logic        sig_base;
    logic [IDX_W-1:0] off_lane;
    logic [IDX_W-1:0] size_lane;
    logic        header_ok;

    assign produces = (i_head.kind == K_SHORT) || (i_head.kind == K_LAST);
    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_head_valid && (!produces || out_free);
    assign is_start = (i_head.kind == K_START);
    assign off_lane  = i_head.idx - IDX_OFF_FIRST;
    assign size_lane = i_head.idx - IDX_SIZE_FIRST;

    // A start byte begins from a fresh signature flag and CRC register.
    always_comb begin
        sig_base   = is_start ? 1'b1 : r_sig_good;
        crc_base   = is_start ? CRC_INIT : r_crc;
        n_sig_good = sig_base;
        if (i_head.idx <= IDX_SIG_END) begin
            n_sig_good = sig_base && (i_head.data_byte == sig_byte(i_head.idx[2:0]));
        end
        n_crc = (i_head.idx >= IDX_CRC_FIRST) ? crc_byte(crc_base, i_head.data_byte) : crc_base;
    end

    always_comb begin
        header_ok = r_sig_good && (r_major == 8'd0) && (r_minor <= MAX_MINOR) && r_fields_ok;
        n_result.status        = ST_NO_MATCH;
        n_result.match_length  = '0;
        n_result.crc_ok        = 1'b0;
        n_result.version_major = '0;
        n_result.version_minor = '0;
        n_result.hdr_offset    = '0;
        n_result.hdr_size      = '0;
        if (i_head.kind == K_SHORT) begin
            n_result.status = i_head.final_chunk ? ST_NO_MATCH : ST_NEED_MORE;
        end else begin
            n_result.crc_ok        = ((n_crc ^ CRC_INIT) == r_stored_crc);
            n_result.version_major = r_major;
            n_result.version_minor = r_minor;
            n_result.hdr_offset    = r_offset;
            n_result.hdr_size      = r_size;
            if (!header_ok) begin
                n_result.status = ST_NO_MATCH;
            end else if ({4'd0, r_total} > r_avail) begin
                if (r_final) begin
                    n_result.status       = ST_PARTIAL;
                    n_result.match_length = r_avail[35:0];
                end else begin
                    n_result.status = ST_NEED_MORE;
                end
            end else begin
                n_result.status       = ST_MATCHED;
                n_result.match_length = r_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind != K_SHORT)) begin
            if (is_start) begin
                r_avail <= i_head.bytes_available;
                r_final <= i_head.final_chunk;
            end
            r_crc <= n_crc;
            case (i_head.idx) inside
                IDX_MAJOR:       r_major <= i_head.data_byte;
                IDX_MINOR:       r_minor <= i_head.data_byte;
                [5'd8:5'd11]:    r_stored_crc[8*i_head.idx[1:0] +: 8] <= i_head.data_byte;
                [5'd12:5'd19]:   r_offset[8*off_lane[2:0] +: 8] <= i_head.data_byte;
                [5'd20:5'd27]:   r_size[8*size_lane[2:0] +: 8] <= i_head.data_byte;
                default:         ;
            endcase
            // Both fields are complete by byte 28, so the length sum is taken there.
            if (i_head.idx == IDX_TOTAL) begin
                r_total     <= HEADER_LEN + {1'b0, r_offset[34:0]} + {1'b0, r_size[34:0]};
                r_fields_ok <= field_in_range(r_offset) && field_in_range(r_size);
            end
        end
        if (o_pop && produces) begin
            r_out <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_good  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && (i_head.kind != K_SHORT)) begin
                r_sig_good <= n_sig_good;
            end
            if (o_pop && produces) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

/* rtl/svzh_checker.sv */
// Port-level checks on the result stream of the 7z start-header validator, bound to the top level.
// Depends on svzh_pkg and seven_zip_header_validator_core_macros.svh.
`default_nettype none
`include "seven_zip_header_validator_core_macros.svh"

module svzh_checker
    import svzh_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [183:0] m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser
);

    // A stalled result keeps its status and payload until taken.
    `SVZH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Only a matched or partial result carries a length.
    `SVZH_ASSERT_SAME(a_len_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ST_NO_MATCH || m_axis_tuser == ST_NEED_MORE), m_axis_tdata[35:0] == 36'd0)

    // A matched or partial length always covers at least the start header itself.
    `SVZH_ASSERT_SAME(a_len_min, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ST_MATCHED || m_axis_tuser == ST_PARTIAL), m_axis_tdata[35:5] != 31'd0)

    // A match implies a supported version and both fields within range.
    `SVZH_ASSERT_SAME(a_match_ok, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ST_MATCHED), (m_axis_tdata[44:37] == 8'd0) && (m_axis_tdata[52:45] <= MAX_MINOR) && (m_axis_tdata[116:88] == 29'd0) && (m_axis_tdata[180:152] == 29'd0))

endmodule

bind seven_zip_header_validator_core svzh_checker u_svzh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
